/* src/integer_to_ascii_formatter_unit_defines.svh */
`ifndef INTEGER_TO_ASCII_FORMATTER_UNIT_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_UNIT_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define ITA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("formatter check failed");

// consequent holds in the cycle after the antecedent
`define ITA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("formatter check failed");

`endif

/* src/ita_pkg.sv */
`default_nettype none

package ita_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int DATA_W      = 32;
    localparam int ND_W        = 4;
    localparam int EFF_W       = (VALUE_WIDTH > DATA_W) ? DATA_W : VALUE_WIDTH;

    // double dabble runs four shifts a cycle over the width rounded up to nibbles
    localparam int DD_CYCLES   = (EFF_W + 3) / 4;
    localparam int DD_BITS     = 4 * DD_CYCLES;
    localparam int CNT_W       = (DD_CYCLES > 1) ? $clog2(DD_CYCLES) : 1;

    localparam int DIGIT_DEPTH = 10;
    localparam int IDX_W       = $clog2(DIGIT_DEPTH);
    localparam int NIB_SEL_W   = $clog2(DATA_W / 4);

    localparam int IN_BITS     = 1 + DATA_W + ND_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 8;

    localparam logic [ND_W-1:0] MAX_HEX = ND_W'(8);

    localparam logic       KIND_DEC = 1'b0;
    localparam logic       KIND_HEX = 1'b1;

    localparam logic [6:0] CHAR_MINUS = 7'h2D;
    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] HEX_ALPHA  = 7'd55;
    localparam logic [3:0] NIB_MASK   = 4'hF;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic count_load;
        logic emit_sign;
        logic emit_char;
    } ita_cmd_t;

    typedef struct packed {
        logic in_hex;
        logic in_nd_zero;
        logic sign_pending;
        logic rem_one;
        logic out_free;
    } ita_stat_t;

endpackage

`default_nettype wire

/* src/integer_to_ascii_formatter_unit.sv */
// first character: a hex transaction goes from idle straight to emitting, while a decimal
// one first runs the double dabble conversion and then a digit count state
// flow: a new value is taken only in idle, after the last character of the previous one;
// the conversion does four shifts a cycle, the output one character a cycle unless stalled
// reset: aresetn synchronous active low, controller idle, output empty, counts cleared
`default_nettype none

module integer_to_ascii_formatter_unit
    import ita_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // channel [0], value [32:1], hex_digits [36:33], zero fill above
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // kind [0]
    input  wire logic                   s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // out_channel [0], char_code [7:1]
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    output logic                        m_tlast
);

    ita_cmd_t  cmd;
    ita_stat_t stat;

    ita_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ita_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

/* src/ita_ctrl.sv */
`default_nettype none

module ita_ctrl
    import ita_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire ita_stat_t stat,
    output ita_cmd_t       cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_FIN  = 3'd2;
    localparam logic [2:0] ST_SIGN = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    if (stat.in_hex) begin
                        // a hex transaction asking for no digits gives nothing
                        if (!stat.in_nd_zero) begin
                            state_next = ST_EMIT;
                        end
                    end else begin
                        state_next = ST_CONV;
                    end
                end
            end
            ST_CONV: begin
                cmd.conv_step = 1'b1;
                if (cnt_reg == CNT_W'(DD_CYCLES - 1)) begin
                    state_next = ST_FIN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FIN: begin
                cmd.count_load = 1'b1;
                state_next = stat.sign_pending ? ST_SIGN : ST_EMIT;
            end
            ST_SIGN: begin
                if (stat.out_free) begin
                    cmd.emit_sign = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit_char = 1'b1;
                    if (stat.rem_one) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

/* src/ita_datapath.sv */
`default_nettype none

module ita_datapath
    import ita_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                   s_tuser,
    input  wire ita_cmd_t               cmd,
    output ita_stat_t                   stat,
    input  wire logic                   m_tready,
    output logic                        m_tvalid,
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    output logic                        m_tlast
);

    logic              in_chan;
    logic [DATA_W-1:0] in_value;
    logic [ND_W-1:0]   in_nd;
    logic [ND_W-1:0]   nd_sat;
    logic [EFF_W-1:0]  vw;
    logic [EFF_W-1:0]  magw;
    logic              neg;

    logic              chan_reg;
    logic              kind_reg;
    logic [DATA_W-1:0] work_reg;
    logic [3:0]        digit_store_reg [DIGIT_DEPTH];
    logic [ND_W-1:0]   digit_count_reg;
    logic              sign_pending_reg;

    logic              m_tvalid_reg;
    logic [6:0]        out_char_reg;
    logic              out_chan_reg;
    logic              out_last_reg;

    logic [3:0]        conv_digits [DIGIT_DEPTH];
    logic [DATA_W-1:0] conv_work;
    logic [ND_W-1:0]   dec_count;
    logic [ND_W-1:0]   cnt_m1;
    logic [3:0]        nib;
    logic [3:0]        dec_digit;
    logic [6:0]        char_code;
    logic              out_free;

    assign in_chan  = s_tdata[0];
    assign in_value = s_tdata[DATA_W:1];
    assign in_nd    = s_tdata[DATA_W+ND_W:DATA_W+1];
    assign nd_sat   = (in_nd > MAX_HEX) ? MAX_HEX : in_nd;

    assign vw   = in_value[EFF_W-1:0];
    assign neg  = vw[EFF_W-1];
    // most negative value stays its own pattern, read as unsigned
    assign magw = neg ? (~vw + 1'b1) : vw;

    // four double dabble shifts per cycle
    always_comb begin
        logic [3:0]        dd [DIGIT_DEPTH];
        logic [DATA_W-1:0] wk;
        dd = digit_store_reg;
        wk = work_reg;
        for (int k = 0; k < 4; k++) begin
            for (int i = 0; i < DIGIT_DEPTH; i++) begin
                if (dd[i] >= 4'd5) begin
                    dd[i] = dd[i] + 4'd3;
                end
            end
            for (int i = DIGIT_DEPTH - 1; i > 0; i--) begin
                dd[i] = {dd[i][2:0], dd[i-1][3]};
            end
            dd[0] = {dd[0][2:0], wk[DD_BITS-1]};
            wk    = wk << 1;
        end
        conv_digits = dd;
        conv_work   = wk;
    end

    // number of significant digits, at least one
    always_comb begin
        dec_count = ND_W'(1);
        for (int i = 1; i < DIGIT_DEPTH; i++) begin
            if (digit_store_reg[i] != 4'd0) begin
                dec_count = ND_W'(i + 1);
            end
        end
    end

    assign cnt_m1    = digit_count_reg - 1'b1;
    assign nib       = 4'(work_reg >> {cnt_m1[NIB_SEL_W-1:0], 2'b00}) & NIB_MASK;
    assign dec_digit = digit_store_reg[cnt_m1[IDX_W-1:0]];

    always_comb begin
        if (kind_reg == KIND_HEX) begin
            char_code = (nib < 4'd10) ? (CHAR_ZERO + 7'(nib)) : (HEX_ALPHA + 7'(nib));
        end else begin
            char_code = CHAR_ZERO + 7'(dec_digit);
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    assign stat.in_hex       = (s_tuser == KIND_HEX);
    assign stat.in_nd_zero   = (nd_sat == '0);
    assign stat.sign_pending = sign_pending_reg;
    assign stat.rem_one      = (digit_count_reg == ND_W'(1));
    assign stat.out_free     = out_free;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            chan_reg <= in_chan;
            kind_reg <= s_tuser;
            if (s_tuser == KIND_HEX) begin
                work_reg <= DATA_W'(vw);
            end else begin
                work_reg <= DATA_W'(magw);
                for (int i = 0; i < DIGIT_DEPTH; i++) begin
                    digit_store_reg[i] <= 4'd0;
                end
            end
        end else if (cmd.conv_step) begin
            work_reg        <= conv_work;
            digit_store_reg <= conv_digits;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_count_reg  <= '0;
            sign_pending_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                if (s_tuser == KIND_HEX) begin
                    digit_count_reg  <= nd_sat;
                    sign_pending_reg <= 1'b0;
                end else begin
                    sign_pending_reg <= neg;
                end
            end else if (cmd.count_load) begin
                digit_count_reg <= dec_count;
            end else if (cmd.emit_sign) begin
                sign_pending_reg <= 1'b0;
            end else if (cmd.emit_char) begin
                digit_count_reg <= cnt_m1;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit_sign || cmd.emit_char) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_sign) begin
            out_char_reg <= CHAR_MINUS;
            out_chan_reg <= chan_reg;
            out_last_reg <= 1'b0;
        end else if (cmd.emit_char) begin
            out_char_reg <= char_code;
            out_chan_reg <= chan_reg;
            out_last_reg <= (digit_count_reg == ND_W'(1));
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_char_reg, out_chan_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

/* src/ita_checker.sv */
`default_nettype none
`include "integer_to_ascii_formatter_unit_defines.svh"

module ita_checker
    import ita_pkg::*;
(
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_tready,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [OUT_TDATA_W-1:0] m_tdata,
    input wire logic                   m_tlast
);

    // stalled result transaction holds
    `ITA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // no new value is taken while characters of the current one are still due
    `ITA_ASSERT_NOW(a_busy, aclk, aresetn, m_tvalid && !m_tlast, !s_tready)

    // only minus, decimal digits or upper-case hex leave the block
    `ITA_ASSERT_NOW(a_char, aclk, aresetn, m_tvalid,
        (m_tdata[7:1] == CHAR_MINUS)
        || ((m_tdata[7:1] >= CHAR_ZERO) && (m_tdata[7:1] <= 7'h39))
        || ((m_tdata[7:1] >= 7'h41) && (m_tdata[7:1] <= 7'h46)))

    // channel tag stays the same across the characters of one value
    `ITA_ASSERT_NEXT(a_chan, aclk, aresetn, m_tvalid && m_tready && !m_tlast,
        !m_tvalid || (m_tdata[0] == $past(m_tdata[0])))

endmodule

bind integer_to_ascii_formatter_unit ita_checker u_ita_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
